/* hdl/tmps_pkg.sv */
package tmps_pkg;

    localparam int PULSE_BITS = 16;
    localparam int POWER_BITS = 7;

    localparam logic [POWER_BITS-1:0] POWER_MAX      = 7'd100;
    localparam logic [POWER_BITS-1:0] SYNC_MIN_POWER = 7'd5;
    localparam logic [PULSE_BITS-1:0] PULSE_FULL     = {PULSE_BITS{1'b1}};
    localparam logic [7:0]            CAL_PERIOD_RESET = 8'd10;
    localparam logic [15:0]           AUTO_STOP_RESET  = 16'd100;

    typedef enum logic [1:0] {
        OP_COMMAND     = 2'd0,
        OP_LEFT_PULSE  = 2'd1,
        OP_RIGHT_PULSE = 2'd2,
        OP_TICK        = 2'd3
    } t_op;

    typedef enum logic {
        CFG_CAL_PERIOD = 1'b0,
        CFG_AUTO_STOP  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_op               op;
        logic signed [7:0] left_command;
        logic signed [7:0] right_command;
        logic              lights_request;
    } t_in_item;

    typedef struct packed {
        logic [POWER_BITS-1:0] left_power;
        logic [POWER_BITS-1:0] right_power;
        logic                  left_backward;
        logic                  right_backward;
        logic                  lights;
        logic                  drive_changed;
    } t_out_item;

endpackage

/* hdl/two_motor_power_sync.sv */
// Two-wheel drive controller with encoder-based power balancing.
// Input channel (i_in_valid / o_in_stall, i_in_item): one item per event:
// a drive command, a left or right encoder pulse, or a timer tick.
// Output channel (o_out_valid / i_out_stall, o_out_item): exactly one item
// per input item, in order, showing the drive state after that event.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data):
// index 0 is the calibration period (low 8 bits of data), index 1 the
// auto-stop tick count; write only while no item is in flight.
// An accepted item passes through the input register, then through the state
// update into the result register.
// Throughput: one item per cycle unless the receiver stalls; the whole
// state update is one logic pass from input register to result register.
// Reset (synchronous, active low) empties both registers, stops both
// motors, clears the pulse and tick counts and loads the register
// defaults (period 10, auto stop 100, the latter also as stop count).
// When the receiver stalls, the result register holds; the input register
// fills and then o_in_stall rises in the same cycle, so no item is lost.
module two_motor_power_sync
    import tmps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  t_cfg_index i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic                  r_in_valid;
    t_in_item              r_in_item;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic [7:0]            r_cal_period;
    logic [15:0]           r_auto_stop;

    logic                  r_left_dir,     n_left_dir;
    logic                  r_right_dir,    n_right_dir;
    logic [POWER_BITS-1:0] r_left_target,  n_left_target;
    logic [POWER_BITS-1:0] r_right_target, n_right_target;
    logic [POWER_BITS-1:0] r_left_actual,  n_left_actual;
    logic [POWER_BITS-1:0] r_right_actual, n_right_actual;
    logic [PULSE_BITS-1:0] r_left_pulses,  n_left_pulses;
    logic [PULSE_BITS-1:0] r_right_pulses, n_right_pulses;
    logic [7:0]            r_tick_count,   n_tick_count;
    logic [15:0]           r_stop_count,   n_stop_count;
    logic                  r_lights,       n_lights;
    logic                  n_changed;

    logic                  adv_out;
    logic                  take_in;

    logic [7:0]            left_neg;
    logic [7:0]            right_neg;
    logic [7:0]            left_mag;
    logic [7:0]            right_mag;

    logic [PULSE_BITS:0]   pulse_sum;
    logic [PULSE_BITS-1:0] pulse_diff;
    logic [PULSE_BITS+5:0] diff_x50;
    logic [PULSE_BITS+2:0] diff_x5;
    logic [PULSE_BITS+1:0] diff_x2;
    logic                  left_slow;
    logic                  left_fast;
    logic [POWER_BITS-1:0] step;
    logic signed [7:0]     err_left;
    logic signed [7:0]     err_right;
    logic                  err_same;
    logic [POWER_BITS-1:0] left_room;
    logic [POWER_BITS-1:0] right_room;
    logic                  sync_en;
    logic [POWER_BITS-1:0] sync_left;
    logic [POWER_BITS-1:0] sync_right;
    logic                  sync_changed;
    logic [POWER_BITS-1:0] upd_left;
    logic [POWER_BITS-1:0] upd_right;
    logic                  upd_changed;

    assign adv_out     = !r_out_valid || !i_out_stall;
    assign take_in     = !r_in_valid || adv_out;
    assign o_in_stall  = !take_in;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    // Correction pass and ramp, from the current state
    always_comb begin
        pulse_sum  = {1'b0, r_left_pulses} + {1'b0, r_right_pulses};
        pulse_diff = (r_left_pulses >= r_right_pulses) ? r_left_pulses - r_right_pulses
                                                       : r_right_pulses - r_left_pulses;
        diff_x50   = (PULSE_BITS+6)'(pulse_diff) * (PULSE_BITS+6)'(50);
        diff_x5    = (PULSE_BITS+3)'(pulse_diff) * (PULSE_BITS+3)'(5);
        diff_x2    = {1'b0, pulse_diff, 1'b0};
        left_slow  = (r_left_pulses < r_right_pulses)
                     && (diff_x50 > (PULSE_BITS+6)'(pulse_sum));
        left_fast  = (r_left_pulses > r_right_pulses)
                     && (diff_x50 > (PULSE_BITS+6)'(pulse_sum));
        if (diff_x2 > (PULSE_BITS+2)'(pulse_sum)) begin
            step = 7'd3;
        end else if (diff_x5 > (PULSE_BITS+3)'(pulse_sum)) begin
            step = 7'd2;
        end else begin
            step = 7'd1;
        end
        err_left   = 8'(r_left_actual) - 8'(r_left_target);
        err_right  = 8'(r_right_actual) - 8'(r_right_target);
        err_same   = (err_left[7] == err_right[7]);
        left_room  = POWER_MAX - r_left_actual;
        right_room = POWER_MAX - r_right_actual;
        sync_en    = (r_left_target == r_right_target) && (r_left_target > SYNC_MIN_POWER)
                     && (pulse_sum != '0);

        sync_left    = r_left_actual;
        sync_right   = r_right_actual;
        sync_changed = 1'b0;
        if (sync_en && left_slow) begin
            sync_changed = 1'b1;
            if (r_left_actual < POWER_MAX
                && ((!err_same && err_left <= err_right)
                    || (err_same && err_left >= err_right))) begin
                sync_left = r_left_actual + ((step < left_room) ? step : left_room);
            end else begin
                sync_right = r_right_actual - ((step < r_right_actual) ? step : r_right_actual);
            end
        end else if (sync_en && left_fast) begin
            sync_changed = 1'b1;
            if (r_right_actual == POWER_MAX
                || (err_same && err_left <= err_right)
                || (!err_same && err_left >= err_right)) begin
                sync_left = r_left_actual - ((step < r_left_actual) ? step : r_left_actual);
            end else begin
                sync_right = r_right_actual + ((step < right_room) ? step : right_room);
            end
        end

        upd_left    = sync_left;
        upd_right   = sync_right;
        upd_changed = sync_changed;
        if (sync_left < r_left_target && sync_right < r_right_target) begin
            upd_left    = sync_left + 1'b1;
            upd_right   = sync_right + 1'b1;
            upd_changed = 1'b1;
        end else if ({1'b0, sync_left} > {1'b0, r_left_target} + 8'd1
                     && {1'b0, sync_right} > {1'b0, r_right_target} + 8'd1) begin
            upd_left    = sync_left - 1'b1;
            upd_right   = sync_right - 1'b1;
            upd_changed = 1'b1;
        end
    end

    // Next state for the item in the input register
    always_comb begin
        n_left_dir     = r_left_dir;
        n_right_dir    = r_right_dir;
        n_left_target  = r_left_target;
        n_right_target = r_right_target;
        n_left_actual  = r_left_actual;
        n_right_actual = r_right_actual;
        n_left_pulses  = r_left_pulses;
        n_right_pulses = r_right_pulses;
        n_tick_count   = r_tick_count;
        n_stop_count   = r_stop_count;
        n_lights       = r_lights;
        n_changed      = 1'b0;

        left_neg  = 8'd0 - r_in_item.left_command;
        right_neg = 8'd0 - r_in_item.right_command;
        left_mag  = r_in_item.left_command[7] ? left_neg : r_in_item.left_command;
        right_mag = r_in_item.right_command[7] ? right_neg : r_in_item.right_command;

        unique case (r_in_item.op)
            OP_COMMAND: begin
                n_left_dir     = r_in_item.left_command[7];
                n_right_dir    = r_in_item.right_command[7];
                n_left_target  = (left_mag > 8'(POWER_MAX)) ? POWER_MAX : left_mag[6:0];
                n_right_target = (right_mag > 8'(POWER_MAX)) ? POWER_MAX : right_mag[6:0];
                n_left_actual  = n_left_target;
                n_right_actual = n_right_target;
                n_left_pulses  = '0;
                n_right_pulses = '0;
                n_stop_count   = r_auto_stop;
                n_lights       = r_in_item.lights_request;
                n_changed      = 1'b1;
            end
            OP_LEFT_PULSE: begin
                if (r_left_pulses != PULSE_FULL) begin
                    n_left_pulses = r_left_pulses + 1'b1;
                end
            end
            OP_RIGHT_PULSE: begin
                if (r_right_pulses != PULSE_FULL) begin
                    n_right_pulses = r_right_pulses + 1'b1;
                end
            end
            OP_TICK: begin
                if (r_stop_count == '0 && (r_left_target != '0 || r_right_target != '0)) begin
                    n_left_target  = '0;
                    n_right_target = '0;
                    n_left_actual  = '0;
                    n_right_actual = '0;
                    n_left_pulses  = '0;
                    n_right_pulses = '0;
                    n_stop_count   = r_auto_stop;
                    n_changed      = 1'b1;
                end else begin
                    if (r_stop_count != '0) begin
                        n_stop_count = r_stop_count - 1'b1;
                    end
                    if (r_tick_count >= r_cal_period) begin
                        n_left_actual  = upd_left;
                        n_right_actual = upd_right;
                        n_changed      = upd_changed;
                    end
                end
                if (r_tick_count >= r_cal_period) begin
                    n_tick_count = 8'd1;
                end else begin
                    n_tick_count = r_tick_count + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_cal_period   <= CAL_PERIOD_RESET;
            r_auto_stop    <= AUTO_STOP_RESET;
            r_left_dir     <= 1'b0;
            r_right_dir    <= 1'b0;
            r_left_target  <= '0;
            r_right_target <= '0;
            r_left_actual  <= '0;
            r_right_actual <= '0;
            r_left_pulses  <= '0;
            r_right_pulses <= '0;
            r_tick_count   <= '0;
            r_stop_count   <= AUTO_STOP_RESET;
            r_lights       <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_CAL_PERIOD: r_cal_period <= i_cfg_data[7:0];
                    CFG_AUTO_STOP:  r_auto_stop  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (take_in) begin
                r_in_valid <= i_in_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_left_dir     <= n_left_dir;
                    r_right_dir    <= n_right_dir;
                    r_left_target  <= n_left_target;
                    r_right_target <= n_right_target;
                    r_left_actual  <= n_left_actual;
                    r_right_actual <= n_right_actual;
                    r_left_pulses  <= n_left_pulses;
                    r_right_pulses <= n_right_pulses;
                    r_tick_count   <= n_tick_count;
                    r_stop_count   <= n_stop_count;
                    r_lights       <= n_lights;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (adv_out && r_in_valid) begin
            r_out_item.left_power     <= n_left_actual;
            r_out_item.right_power    <= n_right_actual;
            r_out_item.left_backward  <= n_left_dir;
            r_out_item.right_backward <= n_right_dir;
            r_out_item.lights         <= n_lights;
            r_out_item.drive_changed  <= n_changed;
        end
    end

endmodule

/* hdl/tmps_checker.sv */
module tmps_checker
    import tmps_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input t_out_item  o_out_item
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output free");

    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.left_power <= POWER_MAX
                        && o_out_item.right_power <= POWER_MAX)
        else $error("power out of range");

endmodule

bind two_motor_power_sync tmps_checker u_tmps_checker (.*);
